// File: rtl/loc_pkg.sv
// ----------------------------------------------------------------------------
// loc_pkg: shared constants and types of the linear odor classifier
// Feature count, class count, weight table depth, fixed feature scales.
// ----------------------------------------------------------------------------
package loc_pkg;

  localparam int FEATURES     = 15;
  localparam int CLASSES      = 6;
  localparam int WEIGHT_COUNT = 90;
  localparam int READINGS     = 11;
  localparam int WADDR_W      = $clog2(WEIGHT_COUNT);
  localparam int CLS_W        = $clog2(CLASSES);
  localparam int FMEM_DEPTH   = 32;
  localparam int FADDR_W      = $clog2(FMEM_DEPTH);
  localparam int SCALED_BASE  = 16;

  localparam logic [6:0] REG_CLASS_THRESHOLD      = 7'd0;
  localparam logic [6:0] REG_LAST_CLASS_THRESHOLD = 7'd1;

  localparam logic KIND_WEIGHT  = 1'b0;
  localparam logic KIND_READING = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SCALE,
    ST_DOT,
    ST_DONE,
    ST_OUT
  } state_t;

  function automatic logic signed [17:0] feat_scale(input logic [3:0] f);
    case (f)
      4'd0:    feat_scale = 18'sd65536;
      4'd1:    feat_scale = 18'sd52429;
      4'd2:    feat_scale = 18'sd39322;
      4'd3:    feat_scale = 18'sd26214;
      4'd4:    feat_scale = 18'sd13107;
      4'd5:    feat_scale = 18'sd58982;
      4'd6:    feat_scale = 18'sd45875;
      4'd7:    feat_scale = 18'sd32768;
      4'd8:    feat_scale = 18'sd19661;
      4'd9:    feat_scale = 18'sd6554;
      4'd10:   feat_scale = 18'sd39322;
      4'd11:   feat_scale = 18'sd26214;
      4'd12:   feat_scale = 18'sd13107;
      4'd13:   feat_scale = 18'sd6554;
      default: feat_scale = 18'sd3277;
    endcase
  endfunction

endpackage

// File: rtl/linear_odor_classifier.sv
// ----------------------------------------------------------------------------
// linear_odor_classifier: fixed-point linear classifier with argmax/threshold
// Weights and readings in synchronous RAMs; one MAC walks features per class.
// ----------------------------------------------------------------------------
// channel  dir  tdata / fields
// s_axis   in   kind(tuser), slot, value (tdata), last (tlast)
// m_axis   out  odor_class, best_score, best_index (tdata)
// cfg      in   index, data
// Weight loads and readings without last go straight to RAM; input stays ready.
// A last reading runs ratio division for four ratios (two reads, one setup,
// 48 quotient bits and one write-back each), then scaling, the MAC over 6
// classes of 15 features and a result register before the output transfer.
// Reset: readings read as zero through per-entry valid bits, no clearing pass.
// Input is held off while a classification runs; the result register holds
// under m_axis_tready low.
module linear_odor_classifier (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // slot[6:0], value[38:7], zero pad
  input  logic        s_axis_tuser,  // kind
  input  logic        s_axis_tlast,  // last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // odor_class[2:0], best_score[50:3], best_index[53:51]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import loc_pkg::*;

  state_t state, state_next;

  logic signed [31:0] class_threshold, last_class_threshold;
  logic signed [31:0] wmem [WEIGHT_COUNT];
  logic signed [31:0] fmem [FMEM_DEPTH];
  logic [READINGS-1:0] rvalid;
  logic signed [31:0] w_rd, f_rd;
  logic [6:0]  slot;
  logic signed [31:0] value;
  logic acc_in;

  // sequencing
  logic [1:0]  pair;
  logic [5:0]  dstep;
  logic        dload;
  logic [3:0]  fidx;
  logic [CLS_W-1:0] cidx;
  logic [WADDR_W-1:0] widx;
  logic        rd_v;
  logic [3:0]  rd_f;
  logic        rd_last_f;
  logic        rd_last_c;
  logic        seq_end;

  // divider
  logic        neg, zero;
  logic [47:0] num;
  logic [31:0] den;
  logic [48:0] rem;
  logic [47:0] quo;
  logic signed [31:0] ratio_val;
  logic signed [31:0] ra;

  logic signed [63:0] acc, best;
  logic [CLS_W-1:0] best_i;
  logic signed [63:0] prod;
  logic signed [49:0] sprod;
  logic signed [33:0] sc;

  assign slot   = s_axis_tdata[6:0];
  assign value  = s_axis_tdata[38:7];
  assign acc_in = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      class_threshold      <= 32'sd45875;
      last_class_threshold <= 32'sd39322;
    end else if (cfg_valid) begin
      if (cfg_index == REG_CLASS_THRESHOLD) class_threshold <= cfg_data;
      else if (cfg_index == REG_LAST_CLASS_THRESHOLD) last_class_threshold <= cfg_data;
    end
  end

  // weight RAM: write on load, registered read during dot product
  always_ff @(posedge clk) begin
    if (acc_in && s_axis_tuser == KIND_WEIGHT && slot < 7'(WEIGHT_COUNT))
      wmem[slot[WADDR_W-1:0]] <= value;
    w_rd <= wmem[widx];
  end

  // feature RAM: readings in 0..10, ratios in 11..14, scaled features from 16
  logic        fw_en;
  logic [FADDR_W-1:0] fw_a;
  logic signed [31:0] fw_d;
  logic [FADDR_W-1:0] fr_a;
  always_ff @(posedge clk) begin
    if (fw_en) fmem[fw_a] <= fw_d;
    f_rd <= fmem[fr_a];
  end

  always_ff @(posedge clk) begin
    if (rst) rvalid <= '0;
    else if (acc_in && s_axis_tuser == KIND_READING && slot < 7'(READINGS))
      rvalid[slot[3:0]] <= 1'b1;
  end

  // read of a never-written reading returns zero
  logic [FADDR_W-1:0] fr_a_q;
  logic signed [31:0] f_val;
  always_ff @(posedge clk) fr_a_q <= fr_a;
  assign f_val = (fr_a_q < FADDR_W'(READINGS) && !rvalid[fr_a_q[3:0]]) ? 32'sd0 : f_rd;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (acc_in && s_axis_tuser == KIND_READING && s_axis_tlast)
                  state_next = ST_DIV;
      ST_DIV:   if (!dload && dstep == 6'd48 && pair == 2'd3) state_next = ST_SCALE;
      ST_SCALE: if (rd_v && rd_last_f) state_next = ST_DOT;
      ST_DOT:   if (rd_v && rd_last_f && rd_last_c) state_next = ST_DONE;
      ST_DONE:  state_next = ST_OUT;
      ST_OUT:   if (m_axis_tready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // feature RAM port muxing
  always_comb begin
    fw_en = 1'b0;
    fw_a  = {1'b0, slot[3:0]};
    fw_d  = value;
    fr_a  = {1'b0, fidx};
    if (acc_in && s_axis_tuser == KIND_READING && slot < 7'(READINGS)) fw_en = 1'b1;
    if (state == ST_DIV) begin
      fr_a = {2'b00, pair, dstep[0]};
      if (!dload && dstep == 6'd48) begin
        fw_en = 1'b1;
        fw_a  = FADDR_W'(READINGS) + FADDR_W'(pair);
        fw_d  = ratio_val;
      end
    end else if (state == ST_SCALE) begin
      if (rd_v) begin
        fw_en = 1'b1;
        fw_a  = FADDR_W'(SCALED_BASE) + {1'b0, rd_f};
        fw_d  = sc[31:0];
      end
    end else if (state == ST_DOT) begin
      fr_a = FADDR_W'(SCALED_BASE) + {1'b0, fidx};
    end
  end

  // ratio: load phase reads a then b, then 48 restoring steps
  always_comb begin
    logic [47:0] q;
    q = quo;
    if (zero) ratio_val = 32'sh7fffffff;
    else if (!neg) ratio_val = (q > 48'h7fffffff) ? 32'sh7fffffff : q[31:0];
    else ratio_val = (q > 48'h80000000) ? 32'sh80000000 : 32'(-q);
  end

  logic [1:0] lphase;
  always_ff @(posedge clk) begin
    if (rst) begin
      pair <= '0; dstep <= '0; dload <= 1'b1; lphase <= '0;
    end else if (state == ST_DIV) begin
      if (dload) begin
        // phase 0 issues a read, 1 issues b & captures a, 2 captures b
        if (lphase == 2'd2) begin
          neg   <= ra[31] ^ f_val[31];
          zero  <= (f_val == 32'sd0);
          num   <= {(ra[31] ? 32'(-ra) : ra), 16'd0};
          den   <= f_val[31] ? 32'(-f_val) : f_val;
          rem   <= '0;
          quo   <= '0;
          dstep <= '0;
          dload <= 1'b0;
          lphase <= '0;
        end else begin
          lphase <= lphase + 2'd1;
          dstep  <= {5'd0, ~dstep[0]};
          if (lphase == 2'd1) ra <= f_val;
        end
      end else if (dstep != 6'd48) begin
        logic [48:0] r2;
        r2 = {rem[47:0], num[47]};
        num <= {num[46:0], 1'b0};
        if (r2 >= {17'd0, den}) begin
          rem <= r2 - {17'd0, den};
          quo <= {quo[46:0], 1'b1};
        end else begin
          rem <= r2;
          quo <= {quo[46:0], 1'b0};
        end
        dstep <= dstep + 6'd1;
      end else begin
        pair  <= pair + 2'd1;
        dload <= 1'b1;
        dstep <= '0;
      end
    end else begin
      pair <= '0; dstep <= '0; dload <= 1'b1; lphase <= '0;
    end
  end

  // scale and dot sequencing: fidx/cidx issue reads, rd_* tag returned data
  assign sprod = 50'(f_val) * 50'(feat_scale(rd_f));
  always_comb begin
    logic signed [49:0] s;
    s = sprod >>> 16;
    if (s > 50'sh7fffffff) sc = 34'sh7fffffff;
    else if (s < -50'sh80000000) sc = -34'sh80000000;
    else sc = s[33:0];
  end
  assign prod = 64'(f_val) * 64'(w_rd);

  assign seq_end = rd_v && rd_last_f && (state == ST_SCALE || rd_last_c);

  always_ff @(posedge clk) begin
    if (rst) begin
      fidx <= '0; cidx <= '0; widx <= '0; rd_v <= 1'b0;
    end else if ((state == ST_SCALE || state == ST_DOT) && !seq_end) begin
      rd_v      <= 1'b1;
      rd_f      <= fidx;
      rd_last_f <= (fidx == 4'(FEATURES-1));
      rd_last_c <= (cidx == CLS_W'(CLASSES-1));
      if (fidx == 4'(FEATURES-1)) begin
        fidx <= '0;
        if (state == ST_DOT) cidx <= cidx + CLS_W'(1);
      end else fidx <= fidx + 4'd1;
      if (state == ST_DOT) widx <= (widx == WADDR_W'(WEIGHT_COUNT-1)) ? '0 : widx + 1'b1;
    end else begin
      fidx <= '0; cidx <= '0; widx <= '0; rd_v <= 1'b0;
    end
  end

  logic [CLS_W-1:0] acc_c;
  always_ff @(posedge clk) begin
    if (state == ST_DIV) begin
      acc <= '0; acc_c <= '0;
    end else if (state == ST_DOT && rd_v) begin
      if (rd_last_f) begin
        if (acc_c == '0 || (acc + (prod >>> 16)) > best) begin
          best   <= acc + (prod >>> 16);
          best_i <= acc_c;
        end
        acc   <= '0;
        acc_c <= acc_c + CLS_W'(1);
      end else acc <= acc + (prod >>> 16);
    end
  end

  logic [2:0]  o_class, o_idx;
  logic [47:0] o_score;
  always_ff @(posedge clk) begin
    if (state == ST_DONE) begin
      logic signed [31:0] th;
      th = (best_i == CLS_W'(CLASSES-1)) ? last_class_threshold : class_threshold;
      o_class <= (best > 64'(th)) ? 3'(best_i + CLS_W'(1)) : 3'd0;
      o_idx   <= 3'(best_i);
      if (best > 64'sh7fffffffffff) o_score <= 48'h7fffffffffff;
      else if (best < -64'sh800000000000) o_score <= 48'h800000000000;
      else o_score <= best[47:0];
    end
  end

  assign m_axis_tvalid = (state == ST_OUT);
  assign m_axis_tdata  = {2'd0, o_idx, o_score, o_class};

  a_no_in_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !s_axis_tready) else $error("input accepted while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result dropped");
  a_idx: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[53:51] < 3'(CLASSES))) else $error("bad index");
endmodule

// File: sim/tb_linear_odor_classifier.sv
// ----------------------------------------------------------------------------
// tb_linear_odor_classifier: self-checking bench for the odor classifier
// Drives weight loads and sensor readings with random gaps, writes both
// thresholds between phases, predicts every classification in a scoreboard
// and checks each output transfer field by field.
// ----------------------------------------------------------------------------
module tb_linear_odor_classifier;
  timeunit 1ns;
  timeprecision 1ps;
  import loc_pkg::*;

  typedef struct packed {
    logic [2:0]         best_index;
    logic signed [47:0] best_score;
    logic [2:0]         odor_class;
  } verdict_t;

  class odor_scoreboard;
    logic signed [31:0] weights[WEIGHT_COUNT];
    logic signed [31:0] readings[READINGS];
    logic signed [31:0] thresh;
    logic signed [31:0] last_thresh;
    verdict_t           verdicts[$];
    int                 errors;
    int                 checked;
    int                 class_hits[8];
    longint             feat_gain[FEATURES] = '{65536, 52429, 39322, 26214, 13107,
                                                58982, 45875, 32768, 19661, 6554,
                                                39322, 26214, 13107, 6554, 3277};

    function new();
      foreach (weights[i]) weights[i] = '0;
      foreach (readings[i]) readings[i] = '0;
      thresh = 32'sd45875;
      last_thresh = 32'sd39322;
      errors = 0;
      checked = 0;
      foreach (class_hits[i]) class_hits[i] = 0;
    endfunction

    function longint sat(longint x, longint lo, longint hi);
      return (x > hi) ? hi : (x < lo) ? lo : x;
    endfunction

    function longint gas_ratio(longint a, longint b);
      if (b == 0) return 64'sd2147483647;
      return sat((a * 65536) / b, -64'sd2147483648, 64'sd2147483647);
    endfunction

    function void write_reg(logic [6:0] idx, logic [31:0] data);
      if (idx == REG_CLASS_THRESHOLD) thresh = data;
      else if (idx == REG_LAST_CLASS_THRESHOLD) last_thresh = data;
    endfunction

    function void note_input(logic kind, logic [6:0] slot, logic signed [31:0] value,
                             logic last);
      longint   feat[FEATURES];
      longint   acc;
      longint   best;
      int       best_i;
      longint   th;
      verdict_t v;
      if (kind == KIND_WEIGHT) begin
        if (slot < WEIGHT_COUNT) weights[slot] = value;
        return;
      end
      if (slot < READINGS) readings[slot] = value;
      if (!last) return;
      for (int f = 0; f < READINGS; f++) feat[f] = longint'(readings[f]);
      for (int r = 0; r < 4; r++)
        feat[11 + r] = gas_ratio(longint'(readings[2 * r]), longint'(readings[2 * r + 1]));
      for (int f = 0; f < FEATURES; f++)
        feat[f] = sat((feat[f] * feat_gain[f]) >>> 16, -64'sd2147483648, 64'sd2147483647);
      best = 0;
      best_i = 0;
      for (int c = 0; c < CLASSES; c++) begin
        acc = 0;
        for (int f = 0; f < FEATURES; f++)
          acc += (feat[f] * longint'(weights[c * FEATURES + f])) >>> 16;
        if (c == 0 || acc > best) begin
          best = acc;
          best_i = c;
        end
      end
      th = (best_i == CLASSES - 1) ? longint'(last_thresh) : longint'(thresh);
      v.odor_class = (best > th) ? 3'(best_i + 1) : 3'd0;
      v.best_score = 48'(sat(best, -(64'sd1 <<< 47), (64'sd1 <<< 47) - 1));
      v.best_index = 3'(best_i);
      verdicts.push_back(v);
    endfunction

    function void report(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
    endfunction

    function void check_result(logic [55:0] tdata);
      verdict_t got;
      verdict_t want;
      got = tdata[53:0];
      checked++;
      if (verdicts.size() == 0) begin
        report("unexpected transfer, odor_class", got.odor_class, -1);
        return;
      end
      want = verdicts.pop_front();
      class_hits[want.odor_class]++;
      if (got.odor_class != want.odor_class) report("odor_class", got.odor_class, want.odor_class);
      if (got.best_score != want.best_score) report("best_score", got.best_score, want.best_score);
      if (got.best_index != want.best_index) report("best_index", got.best_index, want.best_index);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [6:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  odor_scoreboard board = new();
  int          items_sent = 0;
  int          idle_cycles = 0;
  bit          timed_out = 1'b0;

  linear_odor_classifier u_top (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return '0;
      3: return $signed($urandom_range(0, 8 * 65536)) - 4 * 65536;
      default: return $urandom();
    endcase
  endfunction

  task automatic send(logic kind, logic [6:0] slot, logic signed [31:0] value, logic last);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tlast  <= last;
    s_axis_tdata  <= {1'b0, value, slot};
    do @(posedge clk); while (!s_axis_tready);
    board.note_input(kind, slot, value, last);
    items_sent++;
  endtask

  task automatic write_cfg(logic [6:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.verdicts.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic reading_frame();
    for (int ch = 0; ch < READINGS; ch++)
      send(KIND_READING, 7'(ch), pick_value(), ch == READINGS - 1);
  endtask

  // receiver: random stall before each result
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      stall = $urandom_range(0, 4);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      board.check_result(m_axis_tdata);
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000 && !timed_out) begin
      timed_out = 1'b1;
      $display("watchdog expired");
      $display("status: fail");
      $finish;
    end
  end

  logic [31:0] th_main [6] = '{32'd45875, 32'h80000000, 32'h7fffffff, 32'd0, 32'd0, 32'd131072};
  logic [31:0] th_last [6] = '{32'd39322, 32'h80000000, 32'h7fffffff, 32'd0, 32'd0, 32'hffff0000};

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // every weight written before the first classification
    for (int i = 0; i < WEIGHT_COUNT; i++)
      send(KIND_WEIGHT, 7'(i), pick_value(), 1'b0);
    // directed corners
    send(KIND_WEIGHT, 7'd127, 32'sh7fffffff, 1'b1);
    send(KIND_WEIGHT, 7'd90, 32'sh80000000, 1'b0);
    send(KIND_READING, 7'd1, 32'sd0, 1'b0);
    send(KIND_READING, 7'd3, 32'sd0, 1'b0);
    send(KIND_READING, 7'd0, 32'sh80000000, 1'b1);
    send(KIND_READING, 7'd0, 32'sh80000000, 1'b0);
    send(KIND_READING, 7'd1, 32'shffffffff, 1'b1);
    send(KIND_READING, 7'd4, 32'sh7fffffff, 1'b0);
    send(KIND_READING, 7'd5, 32'sd1, 1'b1);
    send(KIND_READING, 7'd11, 32'sh7fffffff, 1'b1);
    send(KIND_READING, 7'd127, 32'sh55555555, 1'b1);
    send(KIND_READING, 7'd10, 32'shaaaaaaaa, 1'b1);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        drain();
        if (ph == 4) begin
          th_main[ph] = $urandom();
          th_last[ph] = $urandom();
        end
        write_cfg(REG_CLASS_THRESHOLD, th_main[ph]);
        write_cfg(REG_LAST_CLASS_THRESHOLD, th_last[ph]);
      end
      while (items_sent < 110 + (ph + 1) * 180) begin
        case ($urandom_range(0, 9))
          0: send(KIND_WEIGHT, 7'($urandom_range(0, 127)), pick_value(), 1'($urandom()));
          1: send(KIND_READING, 7'($urandom_range(0, 127)), pick_value(),
                  $urandom_range(0, 3) == 0);
          2: send(KIND_WEIGHT, 7'($urandom_range(0, WEIGHT_COUNT - 1)),
                  $signed($urandom_range(0, 4 * 65536)) - 2 * 65536, 1'b0);
          default: reading_frame();
        endcase
      end
    end

    drain();
    repeat (300) @(posedge clk);
    $display("covered %0d input transfers and %0d results over 6 threshold settings",
             items_sent, board.checked);
    $display("results by class: unknown %0d, c1 %0d, c2 %0d, c3 %0d, c4 %0d, c5 %0d, c6 %0d",
             board.class_hits[0], board.class_hits[1], board.class_hits[2],
             board.class_hits[3], board.class_hits[4], board.class_hits[5],
             board.class_hits[6]);
    if (board.errors == 0 && board.verdicts.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
